FILE: hdl/izn_pkg.sv
// Package for the Izhikevich neuron step unit: constants, widths, register indexes.
// No dependencies.
`default_nettype none
package izn_pkg;
  localparam int unsigned DigitW = 1;
  localparam logic signed [31:0] VResetValue = -32'sd4259840;
  localparam logic signed [31:0] UResetValue = -32'sd851968;
  localparam logic [15:0] KPoint04 = 16'd2621;
  localparam logic [2:0] RegRate = 3'd0;
  localparam logic [2:0] RegSens = 3'd1;
  localparam logic [2:0] RegCpot = 3'd2;
  localparam logic [2:0] RegJump = 3'd3;
  localparam logic [2:0] RegThr = 3'd4;
  localparam logic [15:0] RateReset = 16'd1311;
  localparam logic [15:0] SensReset = 16'd13107;
  localparam logic [23:0] CpotReset = 24'hBF0000;
  localparam logic [20:0] JumpReset = 21'd524288;
  localparam logic [22:0] ThrReset = 23'd1310720;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
    else if (x < -66'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: hdl/izn_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on nothing; used by izhikevich_neuron_step_unit.
`default_nettype none
module izn_serial_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [47:0] a_i,     // multiplicand
  input  wire logic signed [33:0] b_i,     // multiplier
  output logic                    done_o,
  output logic signed [81:0]      p_o
);
  logic signed [81:0] acc_q, acc_d;
  logic [33:0] mb_q, mb_d;
  logic signed [47:0] ma_q, ma_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic signed [81:0] addend, acc_nx;

  always_comb begin
    addend = {{34{ma_q[47]}}, ma_q} <<< cnt_q;
    acc_nx = acc_q;
    // top bit of a two's complement multiplier has negative weight
    if (mb_q[0]) begin
      if (cnt_q == 6'd33) acc_nx = acc_q - addend;
      else acc_nx = acc_q + addend;
    end
    done_o = busy_q && (cnt_q == 6'd33);
    acc_d = acc_q; mb_d = mb_q; ma_d = ma_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      acc_d = '0; mb_d = b_i; ma_d = a_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_nx;
      mb_d = mb_q >> 1;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd33) busy_d = 1'b0;
    end
  end
  assign p_o = acc_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mb_q <= mb_d;
    ma_q <= ma_d;
  end
endmodule
`default_nettype wire

FILE: hdl/izhikevich_neuron_step_unit.sv
// Izhikevich neuron, one tick per accepted word.
// Each tick runs six products in turn on the shared bit-serial multiplier before
// the result is valid. One word at a time: the next is taken the cycle after
// the result is taken. Reset: v = -65.0, u = -13.0, registers at their
// defaults.
`default_nettype none
module izhikevich_neuron_step_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [26:0] input_current_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    fired_o,
  output logic signed [31:0]      potential_o,
  output logic signed [31:0]      recovery_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam logic [2:0] SIdle = 3'd0, SVV = 3'd1, SQ = 3'd2, SBV = 3'd3,
                         SAD = 3'd4, SOut = 3'd5;
  logic [2:0] st_q, st_d;
  logic half_q, half_d;
  logic [15:0] rate_q, sens_q;
  logic [23:0] cpot_q;
  logic [20:0] jump_q;
  logic [22:0] thr_q;
  logic signed [31:0] v_q, v_d, u_q, u_d;
  logic signed [26:0] cur_q;
  logic signed [65:0] tmp_q, tmp_d;
  logic ov_q, ov_d, fired_q, fired_d;
  logic mstart;
  logic signed [47:0] ma;
  logic signed [33:0] mb;
  logic mdone;
  logic signed [81:0] mp;
  logic signed [65:0] sum, vn, un;

  izn_serial_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (st_q != SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q; half_d = half_q; v_d = v_q; u_d = u_q; tmp_d = tmp_q;
    ov_d = ov_q; fired_d = fired_q;
    mstart = 1'b0; ma = '0; mb = '0;
    sum = '0; vn = '0; un = '0;
    case (st_q)
      SIdle: begin
        if (in_valid_i) begin
          mstart = 1'b1; ma = 48'(v_q); mb = 34'(v_q);
          half_d = 1'b0; st_d = SVV;
        end
      end
      SVV: begin
        if (mdone) begin
          mstart = 1'b1; ma = 48'(mp[63:16]); mb = {18'd0, izn_pkg::KPoint04};
          st_d = SQ;
        end
      end
      SQ: begin
        if (mdone) begin
          sum = 66'(mp[81:16]) + 66'(v_q) * 66'sd5 + (66'sd140 <<< 16)
                - 66'(u_q) + 66'(cur_q);
          vn = 66'(v_q) + (sum >>> 1);
          v_d = izn_pkg::sat32(vn);
          if (!half_q) begin
            half_d = 1'b1;
            mstart = 1'b1; ma = 48'(v_d); mb = 34'(v_d); st_d = SVV;
          end else begin
            mstart = 1'b1; ma = 48'(v_d); mb = {18'd0, sens_q}; st_d = SBV;
          end
        end
      end
      SBV: begin
        if (mdone) begin
          tmp_d = 66'(mp >>> 16) - 66'(u_q);
          mstart = 1'b1; ma = 48'(tmp_d); mb = {18'd0, rate_q}; st_d = SAD;
        end
      end
      SAD: begin
        if (mdone) begin
          un = 66'(u_q) + 66'(mp >>> 16);
          u_d = izn_pkg::sat32(un);
          fired_d = (66'(v_q) > $signed(66'(thr_q)));
          if (fired_d) begin
            v_d = 32'({{8{cpot_q[23]}}, cpot_q});
            u_d = izn_pkg::sat32(66'(u_d) + 66'(jump_q));
          end
          ov_d = 1'b1; st_d = SOut;
        end
      end
      SOut: begin
        if (!out_stall_i) begin
          ov_d = 1'b0; st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; half_q <= 1'b0; ov_q <= 1'b0;
      v_q <= izn_pkg::VResetValue; u_q <= izn_pkg::UResetValue;
      rate_q <= izn_pkg::RateReset; sens_q <= izn_pkg::SensReset;
      cpot_q <= izn_pkg::CpotReset; jump_q <= izn_pkg::JumpReset;
      thr_q <= izn_pkg::ThrReset;
    end else begin
      st_q <= st_d; half_q <= half_d; ov_q <= ov_d;
      v_q <= v_d; u_q <= u_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          izn_pkg::RegRate: rate_q <= cfg_data_i[15:0];
          izn_pkg::RegSens: sens_q <= cfg_data_i[15:0];
          izn_pkg::RegCpot: cpot_q <= cfg_data_i[23:0];
          izn_pkg::RegJump: jump_q <= cfg_data_i[20:0];
          izn_pkg::RegThr:  thr_q <= cfg_data_i[22:0];
          default: ;
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d; fired_q <= fired_d;
    if (st_q == SIdle && in_valid_i) cur_q <= input_current_i;
  end

  assign fired_o = fired_q;
  assign potential_o = v_q;
  assign recovery_o = u_q;
endmodule
`default_nettype wire

FILE: hdl/izn_checker.sv
// Port-level checker for izhikevich_neuron_step_unit, bound to the top level.
// No dependencies.
`default_nettype none
module izn_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [31:0] potential_o
);
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_take_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("no stall after take");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(potential_o)))
    else $error("result dropped");
endmodule
bind izhikevich_neuron_step_unit izn_checker u_chk (.*);
`default_nettype wire

FILE: test/izhikevich_neuron_step_unit_tb.sv
// Testbench for the Izhikevich neuron step unit: drives current words, predicts
// fire flag, potential and recovery per tick, and checks every result word.
// Depends on izn_pkg and izhikevich_neuron_step_unit.
`timescale 1ns / 1ps

module izhikevich_neuron_step_unit_tb;
  import izn_pkg::*;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] potential;
    logic signed [31:0] recovery;
  } tick_t;

  // neuron predictor and queue of expected ticks
  class neuron_board;
    logic [15:0] rate, sens;
    logic signed [23:0] cpot;
    logic [20:0] jump;
    logic [22:0] thr;
    logic signed [31:0] v, u;
    tick_t pending[$];
    int errors;

    function new();
      rate = RateReset; sens = SensReset; cpot = CpotReset;
      jump = JumpReset; thr = ThrReset;
      v = VResetValue; u = UResetValue;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        RegRate: rate = d[15:0];
        RegSens: sens = d[15:0];
        RegCpot: cpot = d[23:0];
        RegJump: jump = d[20:0];
        RegThr:  thr  = d[22:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clip(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function logic signed [31:0] half(logic signed [31:0] pv, logic signed [31:0] pu,
                                      longint cur);
      longint sq, quad, s;
      sq = (longint'(pv) * longint'(pv)) >>> 16;
      quad = (sq * 2621) >>> 16;
      s = quad + 5 * longint'(pv) + (longint'(140) <<< 16) - longint'(pu) + cur;
      return clip(longint'(pv) + (s >>> 1));
    endfunction

    function void note_current(logic signed [26:0] cur);
      logic signed [31:0] nv, nu;
      longint bv;
      tick_t t;
      nv = half(v, u, longint'(cur));
      nv = half(nv, u, longint'(cur));
      bv = (longint'({1'b0, sens}) * longint'(nv)) >>> 16;
      nu = clip(longint'(u) + ((longint'({1'b0, rate}) * (bv - longint'(u))) >>> 16));
      t.fired = longint'(nv) > longint'({1'b0, thr});
      if (t.fired) begin
        nv = cpot;
        nu = clip(longint'(nu) + longint'({1'b0, jump}));
      end
      v = nv; u = nu;
      t.potential = nv; t.recovery = nu;
      pending.push_back(t);
    endfunction

    function void check_tick(tick_t got);
      tick_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp f=%0d v=%0d u=%0d got f=%0d v=%0d u=%0d",
                   e.fired, e.potential, e.recovery,
                   got.fired, got.potential, got.recovery);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0, cfg_valid_i = 0;
  logic signed [26:0] input_current_i = '0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, fired_o, cfg_ready_o;
  logic signed [31:0] potential_o, recovery_o;
  neuron_board board = new();
  int cycles = 0;
  bit hold_long = 0;

  izhikevich_neuron_step_unit uut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: accepted words checked at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_tick({fired_o, potential_o, recovery_o});
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1;
        repeat (3000) @(posedge clk_i);
        hold_long = 0;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) n = 0;
      out_stall_i <= (n != 0);
      repeat (n > 0 ? n : 1) @(posedge clk_i);
    end
  end

  // valid stays up after a take; a gap, drain or the next word moves it
  task automatic send_current(logic signed [26:0] cur);
    int gap;
    gap = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    cfg_valid_i <= 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    input_current_i <= cur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_current(cur);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, d);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [26:0] rand_current();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 30 << 16) - (10 << 16);
      1: return $urandom_range(0, 2000 << 16) - (1000 << 16);
      default: return $urandom_range(0, 131072000) - 65536000;
    endcase
  endfunction

  initial begin
    logic signed [26:0] dir[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // field extremes, bit toggles, firing and saturation
    dir = '{0, 27'sd65536000, -27'sd65536000, 27'sd655360, 27'sd655360, 27'sd655360,
            27'sh3FFFFFF, 27'sh4000000, 27'sh2AAAAAA, 27'sh5555555, -27'sd1,
            27'sd1, 27'sd65536000, 27'sd65536000, 0};
    foreach (dir[i]) send_current(dir[i]);
    drain();
    // extreme register settings
    write_reg(RegRate, 32'hFFFF); write_reg(RegSens, 32'hFFFF);
    write_reg(RegCpot, 32'h800000); write_reg(RegJump, 32'h1FFFFF);
    write_reg(RegThr, 32'h7FFFFF); write_reg(3'd7, 32'h12345678);
    for (int i = 0; i < 6; i++) send_current(i[0] ? 27'sd65536000 : -27'sd65536000);
    drain();
    write_reg(RegRate, 0); write_reg(RegSens, 0); write_reg(RegCpot, 0);
    write_reg(RegJump, 0); write_reg(RegThr, 0);
    for (int i = 0; i < 4; i++) send_current(rand_current());
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegRate, $urandom_range(0, 65535));
      write_reg(RegSens, $urandom_range(0, 65535));
      write_reg(RegCpot, $urandom_range(0, 6553600) * -1);
      write_reg(RegJump, $urandom_range(0, 1310720));
      write_reg(RegThr, $urandom_range(0, 6553600));
      if (ph == 1) hold_long = 1;
      for (int i = 0; i < 120; i++) send_current(rand_current());
      drain();
    end
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
